// ===== rtl/core/jbr_pkg.sv =====
// ----------------------------------------------------------------------------
// jbr_pkg
// Shared types and field widths of the jitter buffer reassembly block.
// ----------------------------------------------------------------------------
`default_nettype none

package jbr_pkg;

  localparam int OP_W        = 2;
  localparam int SEQ_W       = 31;
  localparam int FRM_W       = 7;
  localparam int FIDX_W      = 6;
  localparam int STS_W       = 3;
  localparam int SLOT_W      = 4;
  localparam int ESEQ_W      = 32;
  localparam int FILL_W      = 5;
  localparam int CFG_W       = 5;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 120;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_ADD  = 2'd2,
    OP_FIND = 2'd3
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_FULL      = 3'd2,
    STS_EMPTY     = 3'd3,
    STS_RANGE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_BACK,
    S_SRCH,
    S_CMP,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/jitter_buffer_reassembly.sv =====
// ----------------------------------------------------------------------------
// jitter_buffer_reassembly
// Ring jitter buffer of audio blocks with sequence lookup and frame tracking.
// ----------------------------------------------------------------------------
// One word is handled at a time; in_tready is high only while the sequencer
// is idle, and a finished result waits in the output register without
// blocking the next input. Entries live in a single RAM with one registered
// read port, so the data of every read is registered before it is compared.
// Push and the full, empty and miss-on-empty rejects finish in dispatch; pop
// first reads the tail entry, a lookup first reads the newest entry, and a
// binary search reads and compares one middle entry per step, then reads and
// compares the final candidate of each of at most two ring segments.
// A write to cfg_data sets the ring depth (clamped to 1..RING_DEPTH) and
// empties the buffer.
`default_nettype none

module jitter_buffer_reassembly #(
  parameter int RING_DEPTH = 16,
  parameter int MAX_FRAMES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // cfg_data: depth_in_use
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [jbr_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // in_tdata: seq[30:0], frame_count[37:31], frame_index[43:38], zero pad
  input  wire logic [jbr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: op[1:0]
  input  wire logic [jbr_pkg::OP_W-1:0]          in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_tdata: slot[3:0], entry_seq[35:4], frames_received[42:36],
  // complete[43], fill_level[48:44], last_pushed[80:49],
  // last_popped[112:81], zero pad
  output logic [jbr_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // out_tuser: status[2:0]
  output logic [jbr_pkg::STS_W-1:0]              out_tuser
);

  import jbr_pkg::*;

  localparam int IW  = $clog2(RING_DEPTH);
  localparam int PW  = $clog2(RING_DEPTH + 1);
  localparam int EW  = SEQ_W + 2 * FRM_W + MAX_FRAMES;
  localparam int DEPTH_RST = (RING_DEPTH < 16) ? RING_DEPTH : 16;

  state_t state_r, state_nxt;

  logic [PW-1:0]     depth_r, depth_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     tail_r, tail_nxt;
  logic [PW-1:0]     count_r, count_nxt;
  logic [ESEQ_W-1:0] pushed_r, pushed_nxt;
  logic [ESEQ_W-1:0] popped_r, popped_nxt;

  logic [PW-1:0]     first_r, first_nxt;
  logic [PW-1:0]     len_r, len_nxt;
  logic [PW-1:0]     hi_r, hi_nxt;
  logic              second_r, second_nxt;

  op_t               op_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [FRM_W-1:0]  nfr_r;
  logic [FIDX_W-1:0] which_r;

  logic              out_valid_r, out_valid_nxt;
  logic [STS_W-1:0]  o_status_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic [ESEQ_W-1:0] o_eseq_r;
  logic [FRM_W-1:0]  o_rec_r;
  logic              o_cmp_r;
  logic [FILL_W-1:0] o_fill_r;
  logic [ESEQ_W-1:0] o_push_r;
  logic [ESEQ_W-1:0] o_pop_r;

  logic              res_load;
  status_t           res_status;
  logic [IW-1:0]     res_slot;
  logic [ESEQ_W-1:0] res_seq;
  logic [FRM_W-1:0]  res_rec;
  logic              res_cmp;

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [EW-1:0]     rd_data;

  logic [SEQ_W-1:0]      rd_seq;
  logic [FRM_W-1:0]      rd_tot;
  logic [FRM_W-1:0]      rd_rec;
  logic [MAX_FRAMES-1:0] rd_mask;

  logic [FRM_W-1:0]      nfr_sat;
  logic [MAX_FRAMES-1:0] push_mask;
  logic [MAX_FRAMES-1:0] sel;
  logic                  bit_hit;
  logic                  add_bad;
  logic [MAX_FRAMES-1:0] upd_mask;
  logic [FRM_W-1:0]      upd_rec;

  logic [IW-1:0] back_idx;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;
  logic [IW-1:0] head_wrap;
  logic [IW-1:0] tail_wrap;
  logic [PW-1:0] half;
  logic [PW-1:0] mid;
  logic [31:0]   cfg_d32;

  logic out_free;
  logic hit_go;
  logic range_end;
  logic [IW-1:0] hit_slot;

  jbr_ram #(
    .WIDTH (EW),
    .DEPTH (RING_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_seq  = rd_data[SEQ_W-1:0];
  assign rd_tot  = rd_data[SEQ_W +: FRM_W];
  assign rd_rec  = rd_data[SEQ_W + FRM_W +: FRM_W];
  assign rd_mask = rd_data[SEQ_W + 2 * FRM_W +: MAX_FRAMES];

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    nfr_sat = (nfr_r > FRM_W'(MAX_FRAMES)) ? FRM_W'(MAX_FRAMES) : nfr_r;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      push_mask[i] = (FRM_W'(i) < nfr_sat);
      sel[i]       = (which_r == FIDX_W'(i));
    end
    bit_hit  = |(rd_mask & sel);
    add_bad  = ({1'b0, which_r} >= rd_tot);
    upd_mask = rd_mask & ~sel;
    upd_rec  = rd_rec + FRM_W'(bit_hit);

    back_idx  = (head_r == '0) ? IW'(depth_r - 1'b1) : head_r - 1'b1;
    head_inc  = PW'(head_r) + 1'b1;
    tail_inc  = PW'(tail_r) + 1'b1;
    head_wrap = (head_inc >= depth_r) ? '0 : IW'(head_inc);
    tail_wrap = (tail_inc >= depth_r) ? '0 : IW'(tail_inc);
    half      = len_r >> 1;
    mid       = first_r + half;

    cfg_d32 = 32'(cfg_data);
    if (cfg_d32 == 32'd0) begin
      cfg_d32 = 32'd1;
    end
    if (cfg_d32 > 32'(RING_DEPTH)) begin
      cfg_d32 = 32'(RING_DEPTH);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    pushed_nxt = pushed_r;
    popped_nxt = popped_r;
    first_nxt  = first_r;
    len_nxt    = len_r;
    hi_nxt     = hi_r;
    second_nxt = second_r;

    res_load   = 1'b0;
    res_status = STS_NOT_FOUND;
    res_slot   = '0;
    res_seq    = '1;
    res_rec    = '0;
    res_cmp    = 1'b0;

    wr_en   = 1'b0;
    wr_addr = head_r;
    wr_data = {push_mask, {FRM_W{1'b0}}, nfr_sat, seq_r};
    rd_en   = 1'b0;
    rd_addr = tail_r;

    hit_go    = 1'b0;
    range_end = 1'b0;
    hit_slot  = (state_r == S_BACK) ? back_idx : IW'(first_r);

    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          depth_nxt  = PW'(cfg_d32);
          head_nxt   = '0;
          tail_nxt   = '0;
          count_nxt  = '0;
          pushed_nxt = '1;
          popped_nxt = '1;
        end
        if (in_tvalid) begin
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (op_r)
          OP_PUSH: begin
            if (out_free) begin
              res_load  = 1'b1;
              state_nxt = S_IDLE;
              if (count_r >= depth_r) begin
                res_status = STS_FULL;
              end else begin
                wr_en      = 1'b1;
                head_nxt   = head_wrap;
                count_nxt  = count_r + 1'b1;
                pushed_nxt = {1'b0, seq_r};
                res_status = STS_OK;
                res_slot   = head_r;
                res_seq    = {1'b0, seq_r};
                res_cmp    = (nfr_sat == '0);
              end
            end
          end
          OP_POP: begin
            if (count_r == '0) begin
              if (out_free) begin
                res_load   = 1'b1;
                res_status = STS_EMPTY;
                state_nxt  = S_IDLE;
              end
            end else begin
              rd_en     = 1'b1;
              rd_addr   = tail_r;
              state_nxt = S_POP;
            end
          end
          default: begin
            if (count_r == '0) begin
              if (out_free) begin
                res_load  = 1'b1;
                state_nxt = S_IDLE;
              end
            end else begin
              rd_en     = 1'b1;
              rd_addr   = back_idx;
              state_nxt = S_BACK;
            end
          end
        endcase
      end

      S_POP: begin
        if (out_free) begin
          popped_nxt = {1'b0, rd_seq};
          tail_nxt   = tail_wrap;
          count_nxt  = count_r - 1'b1;
          res_load   = 1'b1;
          res_status = STS_OK;
          res_slot   = tail_r;
          res_seq    = {1'b0, rd_seq};
          res_rec    = rd_rec;
          res_cmp    = (rd_rec == rd_tot);
          state_nxt  = S_IDLE;
        end
      end

      S_BACK: begin
        if (rd_seq == seq_r) begin
          hit_go = 1'b1;
        end else if (PW'(head_r) > PW'(tail_r)) begin
          first_nxt  = PW'(tail_r);
          hi_nxt     = PW'(head_r);
          len_nxt    = PW'(head_r) - PW'(tail_r);
          second_nxt = 1'b0;
          state_nxt  = S_SRCH;
        end else begin
          first_nxt  = '0;
          hi_nxt     = PW'(head_r);
          len_nxt    = PW'(head_r);
          second_nxt = 1'b1;
          state_nxt  = S_SRCH;
        end
      end

      S_SRCH: begin
        if (len_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = IW'(mid);
          state_nxt = S_CMP;
        end else if (first_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = IW'(first_r);
          state_nxt = S_FIN;
        end else begin
          range_end = 1'b1;
        end
      end

      S_CMP: begin
        if (rd_seq < seq_r) begin
          first_nxt = mid + 1'b1;
          len_nxt   = len_r - half - 1'b1;
        end else begin
          len_nxt   = half;
        end
        state_nxt = S_SRCH;
      end

      S_FIN: begin
        if (rd_seq == seq_r) begin
          hit_go = 1'b1;
        end else begin
          range_end = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (range_end) begin
      if (second_r) begin
        first_nxt  = PW'(tail_r);
        hi_nxt     = depth_r;
        len_nxt    = (depth_r > PW'(tail_r)) ? depth_r - PW'(tail_r) : '0;
        second_nxt = 1'b0;
        state_nxt  = S_SRCH;
      end else if (out_free) begin
        res_load  = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        state_nxt = state_r;
      end
    end

    if (hit_go) begin
      if (out_free) begin
        res_load   = 1'b1;
        res_status = STS_OK;
        res_slot   = hit_slot;
        res_seq    = {1'b0, rd_seq};
        res_rec    = rd_rec;
        res_cmp    = (rd_rec == rd_tot);
        state_nxt  = S_IDLE;
        if (op_r == OP_ADD) begin
          if (add_bad) begin
            res_status = STS_RANGE;
          end else begin
            wr_en   = 1'b1;
            wr_addr = hit_slot;
            wr_data = {upd_mask, upd_rec, rd_tot, rd_seq};
            res_rec = upd_rec;
            res_cmp = (upd_rec == rd_tot);
          end
        end
      end else begin
        state_nxt = state_r;
      end
    end

    out_valid_nxt = (out_valid_r && !out_tready) || res_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= PW'(DEPTH_RST);
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pushed_r    <= '1;
      popped_r    <= '1;
      first_r     <= '0;
      len_r       <= '0;
      hi_r        <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      pushed_r    <= pushed_nxt;
      popped_r    <= popped_nxt;
      first_r     <= first_nxt;
      len_r       <= len_nxt;
      hi_r        <= hi_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= op_t'(in_tuser);
      seq_r   <= in_tdata[SEQ_W-1:0];
      nfr_r   <= in_tdata[SEQ_W +: FRM_W];
      which_r <= in_tdata[SEQ_W + FRM_W +: FIDX_W];
    end
    if (res_load) begin
      o_status_r <= res_status;
      o_slot_r   <= SLOT_W'(res_slot);
      o_eseq_r   <= res_seq;
      o_rec_r    <= res_rec;
      o_cmp_r    <= res_cmp;
      o_fill_r   <= FILL_W'(count_nxt);
      o_push_r   <= pushed_nxt;
      o_pop_r    <= popped_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {7'd0, o_pop_r, o_push_r, o_fill_r, o_cmp_r, o_rec_r,
                       o_eseq_r, o_slot_r};

endmodule

`default_nettype wire

// ===== rtl/core/jbr_ram.sv =====
// ----------------------------------------------------------------------------
// jbr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module jbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the jitter buffer reassembly block. A table of
// directed words walks through the empty, full and range cases, a one-slot
// ring and depth clamping. Random words follow over several ring depths,
// mostly well-formed pushes of rising sequences with frame adds and finds
// on held blocks. Results are compared against the table's expected words or a local ring predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import jbr_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int MAX_FRAMES  = 64;
  localparam int DRAIN       = 40;
  localparam int STALL_LIMIT = 5000;
  localparam logic [31:0] NO_SEQ  = 32'hFFFF_FFFF;
  localparam logic [30:0] SEQ_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [31:0] eseq;
    logic [6:0]  rcvd;
    logic        done;
    logic [4:0]  fill;
    logic [31:0] lpush;
    logic [31:0] lpop;
  } jb_result_t;

  typedef struct packed {
    logic        cfg_pre;
    logic [4:0]  cfg_val;
    op_t         op;
    logic [30:0] seq;
    logic [6:0]  nfr;
    logic [5:0]  fidx;
    logic        typed;
    jb_result_t  want;
  } jb_row_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STS_W-1:0]       out_tuser;

  jitter_buffer_reassembly #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_FRAMES(MAX_FRAMES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predicted ring contents
  bit [31:0]   ring_seq   [RING_DEPTH];
  bit [63:0]   ring_miss  [RING_DEPTH];
  bit [6:0]    ring_total [RING_DEPTH];
  int unsigned rd_head    = 0;
  int unsigned rd_tail    = 0;
  int unsigned rd_fill    = 0;
  int unsigned rd_depth   = RING_DEPTH;
  bit [31:0]   seq_pushed = NO_SEQ;
  bit [31:0]   seq_popped = NO_SEQ;

  jb_result_t  pending_results [$];
  int          errors        = 0;
  int          results_seen  = 0;
  int          send_gap_pct  = 0;
  int          take_stall_pct = 0;
  int          quiet_cycles  = 0;
  bit [30:0]   next_seq      = '0;
  jb_result_t  seen;
  jb_result_t  want_r;

  function automatic void ring_configure(bit [4:0] v);
    rd_depth   = (v == 0) ? 1 : (v > RING_DEPTH) ? RING_DEPTH : v;
    rd_head    = 0;
    rd_tail    = 0;
    rd_fill    = 0;
    seq_pushed = NO_SEQ;
    seq_popped = NO_SEQ;
  endfunction

  // lower bound over [lo, hi), hit only on an exact match
  function automatic int seek(int unsigned lo, int unsigned hi, bit [31:0] key);
    int unsigned first;
    int unsigned len;
    int unsigned half;
    int unsigned mid;
    first = lo;
    len   = (hi > lo) ? hi - lo : 0;
    while (len > 0) begin
      half = len / 2;
      mid  = first + half;
      if (mid < RING_DEPTH && ring_seq[mid] < key) begin
        first = mid + 1;
        len   = len - (half + 1);
      end else begin
        len = half;
      end
    end
    if (first < hi && first < RING_DEPTH && ring_seq[first] == key) return int'(first);
    return -1;
  endfunction

  // newest entry first, then the ordered region, split when wrapped
  function automatic int find_slot(bit [31:0] key);
    int unsigned back;
    int r;
    if (rd_fill == 0) return -1;
    back = (rd_head == 0) ? rd_depth - 1 : rd_head - 1;
    if (ring_seq[back] == key) return int'(back);
    if (rd_head > rd_tail) return seek(rd_tail, rd_head, key);
    r = seek(0, rd_head, key);
    if (r < 0) r = seek(rd_tail, rd_depth, key);
    return r;
  endfunction

  function automatic jb_result_t ring_apply(op_t op, bit [30:0] seq, bit [6:0] nfr,
                                            bit [5:0] fidx);
    jb_result_t r;
    int s;
    int unsigned tot;
    int unsigned miss;
    r = '0;
    r.status = STS_OK;
    s = -1;
    case (op)
      OP_PUSH: begin
        if (rd_fill >= rd_depth) begin
          r.status = STS_FULL;
        end else begin
          if (nfr > MAX_FRAMES) nfr = 7'(MAX_FRAMES);
          ring_seq[rd_head]   = {1'b0, seq};
          ring_total[rd_head] = nfr;
          ring_miss[rd_head]  = (nfr >= 64) ? '1 : ((64'd1 << nfr) - 64'd1);
          s = rd_head;
          rd_head = (rd_head + 1 >= rd_depth) ? 0 : rd_head + 1;
          rd_fill++;
          seq_pushed = {1'b0, seq};
        end
      end
      OP_POP: begin
        if (rd_fill == 0) begin
          r.status = STS_EMPTY;
        end else begin
          seq_popped = ring_seq[rd_tail];
          s = rd_tail;
          rd_tail = (rd_tail + 1 >= rd_depth) ? 0 : rd_tail + 1;
          rd_fill--;
        end
      end
      default: begin
        s = find_slot({1'b0, seq});
        if (s < 0) begin
          r.status = STS_NOT_FOUND;
        end else if (op == OP_ADD) begin
          if (fidx >= ring_total[s]) r.status = STS_RANGE;
          else ring_miss[s][fidx] = 1'b0;
        end
      end
    endcase
    if (s >= 0) begin
      tot    = ring_total[s];
      miss   = $countones(ring_miss[s]);
      r.slot = s[3:0];
      r.eseq = ring_seq[s];
      r.rcvd = 7'((tot > miss) ? tot - miss : 0);
      r.done = (ring_miss[s] == 0);
    end else begin
      r.eseq = NO_SEQ;
    end
    r.fill  = rd_fill[4:0];
    r.lpush = seq_pushed;
    r.lpop  = seq_popped;
    return r;
  endfunction

  function automatic jb_result_t res(status_t st, logic [3:0] slot, logic [31:0] eseq,
                                     logic [6:0] rcvd, logic done, logic [4:0] fill,
                                     logic [31:0] lpush, logic [31:0] lpop);
    jb_result_t r;
    r = '{st, slot, eseq, rcvd, done, fill, lpush, lpop};
    return r;
  endfunction

  function automatic jb_row_t row(logic cfg_pre, logic [4:0] cfg_val, op_t op,
                                  logic [30:0] seq, logic [6:0] nfr, logic [5:0] fidx,
                                  logic typed, jb_result_t want);
    jb_row_t r;
    r = '{cfg_pre, cfg_val, op, seq, nfr, fidx, typed, want};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    errors++;
  endtask

  task automatic send_word(input op_t op, input bit [30:0] seq, input bit [6:0] nfr,
                           input bit [5:0] fidx, input bit typed, input jb_result_t want);
    jb_result_t r;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, fidx, nfr, seq};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    r = ring_apply(op, seq, nfr, fidx);
    pending_results.insert(pending_results.size(), typed ? want : r);
  endtask

  // drain the pipe before touching the depth register
  task automatic write_depth(input bit [4:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ring_configure(v);
  endtask

  task automatic random_items(input int n);
    op_t op;
    bit [30:0] seq;
    bit [6:0] nfr;
    bit [5:0] fidx;
    int unsigned pick;
    int unsigned roll;
    int unsigned idx;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      seq  = 31'($urandom);
      nfr  = 7'($urandom);
      fidx = 6'($urandom);
      if (pick < 30 || (rd_fill == 0 && pick < 85)) op = OP_PUSH;
      else if (pick < 50) op = OP_POP;
      else if (pick < 85) op = OP_ADD;
      else op = OP_FIND;
      if (op == OP_PUSH && rd_fill >= rd_depth && $urandom_range(0, 3) != 0) op = OP_POP;
      roll = $urandom_range(0, 99);
      if (op == OP_PUSH) begin
        if (roll < 85) begin
          seq      = next_seq;
          next_seq = next_seq + 31'($urandom_range(1, 4));
        end
        roll = $urandom_range(0, 99);
        if (roll < 70) nfr = 7'($urandom_range(1, 6));
        else if (roll < 90) nfr = 7'($urandom_range(0, MAX_FRAMES));
      end else if (op != OP_POP && rd_fill > 0 && roll < 85) begin
        idx = (rd_tail + $urandom_range(0, rd_fill - 1)) % rd_depth;
        seq = ring_seq[idx][30:0];
        if (op == OP_ADD && ring_total[idx] != 0 && $urandom_range(0, 99) < 85)
          fidx = 6'($urandom_range(0, ring_total[idx] - 1));
      end
      send_word(op, seq, nfr, fidx, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= take_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("word with no expectation", {29'd0, out_tuser}, '0);
      end else begin
        want_r      = pending_results[0];
        pending_results.delete(0);
        seen.status = status_t'(out_tuser);
        seen.slot   = out_tdata[3:0];
        seen.eseq   = out_tdata[35:4];
        seen.rcvd   = out_tdata[42:36];
        seen.done   = out_tdata[43];
        seen.fill   = out_tdata[48:44];
        seen.lpush  = out_tdata[80:49];
        seen.lpop   = out_tdata[112:81];
        if (seen.status !== want_r.status) report_mismatch("status", seen.status, want_r.status);
        if (seen.slot !== want_r.slot) report_mismatch("slot", seen.slot, want_r.slot);
        if (seen.eseq !== want_r.eseq) report_mismatch("entry_seq", seen.eseq, want_r.eseq);
        if (seen.rcvd !== want_r.rcvd)
          report_mismatch("frames_received", seen.rcvd, want_r.rcvd);
        if (seen.done !== want_r.done) report_mismatch("complete", seen.done, want_r.done);
        if (seen.fill !== want_r.fill) report_mismatch("fill_level", seen.fill, want_r.fill);
        if (seen.lpush !== want_r.lpush)
          report_mismatch("last_pushed", seen.lpush, want_r.lpush);
        if (seen.lpop !== want_r.lpop) report_mismatch("last_popped", seen.lpop, want_r.lpop);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    jb_row_t dir_rows [$];
    bit [4:0] depth_plan [7];
    dir_rows = '{
      row(0, 0, OP_POP,  0,       0,   0,  1, res(STS_EMPTY,     0, NO_SEQ, 0, 0, 0, NO_SEQ,
                                                  NO_SEQ)),
      row(0, 0, OP_FIND, 0,       0,   0,  1, res(STS_NOT_FOUND, 0, NO_SEQ, 0, 0, 0, NO_SEQ,
                                                  NO_SEQ)),
      row(0, 0, OP_ADD,  SEQ_MAX, 0,   63, 1, res(STS_NOT_FOUND, 0, NO_SEQ, 0, 0, 0, NO_SEQ,
                                                  NO_SEQ)),
      row(0, 0, OP_PUSH, SEQ_MAX, 0,   0,  1, res(STS_OK, 0, SEQ_MAX, 0, 1, 1, SEQ_MAX,
                                                  NO_SEQ)),
      row(0, 0, OP_FIND, SEQ_MAX, 0,   0,  1, res(STS_OK, 0, SEQ_MAX, 0, 1, 1, SEQ_MAX,
                                                  NO_SEQ)),
      row(0, 0, OP_ADD,  SEQ_MAX, 0,   0,  1, res(STS_RANGE, 0, SEQ_MAX, 0, 1, 1, SEQ_MAX,
                                                  NO_SEQ)),
      row(0, 0, OP_POP,  0,       0,   0,  1, res(STS_OK, 0, SEQ_MAX, 0, 1, 0, SEQ_MAX,
                                                  SEQ_MAX)),
      row(0, 0, OP_PUSH, 0,       127, 0,  1, res(STS_OK, 1, 0, 0, 0, 1, 0, SEQ_MAX)),
      row(0, 0, OP_ADD,  0,       0,   63, 1, res(STS_OK, 1, 0, 1, 0, 1, 0, SEQ_MAX)),
      row(0, 0, OP_ADD,  0,       0,   0,  0, '0),
      row(0, 0, OP_PUSH, 100,     64,  0,  0, '0),
      row(0, 0, OP_PUSH, 200,     1,   0,  0, '0),
      row(0, 0, OP_PUSH, 300,     2,   0,  0, '0),
      row(0, 0, OP_ADD,  200,     0,   0,  0, '0),
      row(0, 0, OP_FIND, 100,     0,   0,  0, '0),
      row(0, 0, OP_FIND, 150,     0,   0,  1, res(STS_NOT_FOUND, 0, NO_SEQ, 0, 0, 4, 300,
                                                  SEQ_MAX)),
      row(0, 0, OP_ADD,  300,     0,   2,  0, '0),
      row(0, 0, OP_ADD,  100,     0,   63, 0, '0),
      row(1, 0, OP_PUSH, 7,       3,   0,  1, res(STS_OK, 0, 7, 0, 0, 1, 7, NO_SEQ)),
      row(0, 0, OP_PUSH, 8,       3,   0,  1, res(STS_FULL, 0, NO_SEQ, 0, 0, 1, 7, NO_SEQ)),
      row(0, 0, OP_FIND, 7,       0,   0,  0, '0),
      row(0, 0, OP_POP,  0,       0,   0,  1, res(STS_OK, 0, 7, 0, 0, 0, 7, 7)),
      row(0, 0, OP_POP,  0,       0,   0,  1, res(STS_EMPTY, 0, NO_SEQ, 0, 0, 0, 7, 7)),
      row(1, 31, OP_PUSH, 9,      5,   0,  0, '0)
    };
    depth_plan = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd5, 5'd17, 5'd9};
    depth_plan[6] = 5'($urandom_range(0, 31));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct   = 31;
    take_stall_pct = 74;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_pre) write_depth(dir_rows[i].cfg_val);
      send_word(dir_rows[i].op, dir_rows[i].seq, dir_rows[i].nfr, dir_rows[i].fidx,
                dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 2) begin
        send_gap_pct   = 74;
        take_stall_pct = 31;
      end else if (ph == 5) begin
        send_gap_pct   = 0;
        take_stall_pct = 0;
      end
      write_depth(depth_plan[ph]);
      next_seq = 31'($urandom);
      random_items(147);
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== jitter_buffer_reassembly.f =====
rtl/core/jbr_pkg.sv
rtl/core/jbr_ram.sv
rtl/core/jitter_buffer_reassembly.sv
tb/sv/tb.sv
